@@ design/dvrt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the route table engine.
`default_nettype none
package dvrt_pkg;

  localparam int NBR_SLOTS = 32;
  localparam int RT_SLOTS  = 32;
  localparam int ADDR_W    = 48;
  localparam int NBR_AW    = $clog2(NBR_SLOTS);
  localparam int RT_AW     = $clog2(RT_SLOTS);
  localparam int SLOT_MAX  = (NBR_SLOTS > RT_SLOTS) ? NBR_SLOTS : RT_SLOTS;
  localparam int IDX_W     = $clog2(SLOT_MAX + 1);
  localparam int NCNT_W    = $clog2(NBR_SLOTS + 1);
  localparam int RCNT_W    = $clog2(RT_SLOTS + 1);
  localparam int NBR_W     = ADDR_W + 24;
  localparam int RT_W      = 2 * ADDR_W + 16;

  localparam logic [1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [1:0] CFG_SUCC_WT  = 2'd1;
  localparam logic [1:0] CFG_RAND_WT  = 2'd2;

  localparam logic [8:0] SUCC_WT_RESET = 9'd205;
  localparam logic [8:0] RAND_WT_RESET = 9'd51;

  typedef enum logic [1:0] {
    KIND_HELLO,
    KIND_ROUTE,
    KIND_LOOKUP,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    ACT_ADDED,
    ACT_REPLACED,
    ACT_REJECTED,
    ACT_OWN,
    ACT_FULL,
    ACT_FOUND,
    ACT_MISSED,
    ACT_UNKNOWN
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NRD,
    ST_NCMP,
    ST_HMUL,
    ST_HFIN,
    ST_RMUL,
    ST_DIVI,
    ST_DIV,
    ST_DIVF,
    ST_OWN,
    ST_RRD,
    ST_RCMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic nbr_rd;
    logic nbr_latch;
    logic nbr_new;
    logic set_nfull;
    logic hello_mul;
    logic hello_fin;
    logic route_mul;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic rt_rd;
    logic hit_lookup;
    logic hit_offer;
    logic rt_add;
    logic act_we;
    act_t act;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  n_end;
    logic  n_match;
    logic  n_full;
    logic  own_match;
    logic  r_end;
    logic  r_match;
    logic  r_full;
    logic  div_done;
    logic  out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ design/distance_vector_route_table.sv @@
// Top level of the distance-vector route table engine.
//  channel  | handshake           | payload
//  in       | in_valid / in_stall | kind, neighbor_addr, sequence_req, randomness,
//           |                     | dest_addr, adv_distance, adv_metric
//  out      | out_valid/out_stall | neighbor_slot .. neighbor_full
//  cfg      | cfg_we              | cfg_index, cfg_data
// One word at a time. Each table search steps through its entries with a RAM read state
// and a compare state; a route word adds a multiply and a setup state, a 16-step serial
// divide and a finish state. A word may also wait on out_stall when a result is already pending.
// Sync reset clears counts so both tables start empty; no memory clearing pass.
// The next word is taken while a finished result waits on out_stall.
`default_nettype none
module distance_vector_route_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   kind,
  input  wire logic [47:0]  neighbor_addr,
  input  wire logic [7:0]   sequence_req,
  input  wire logic [7:0]   randomness,
  input  wire logic [47:0]  dest_addr,
  input  wire logic [7:0]   adv_distance,
  input  wire logic [7:0]   adv_metric,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [4:0]        neighbor_slot,
  output logic [7:0]        neighbor_metric,
  output logic [2:0]        route_action,
  output logic [4:0]        route_slot,
  output logic [7:0]        route_metric,
  output logic [47:0]       next_hop,
  output logic [5:0]        route_total,
  output logic              neighbor_full
);

  dvrt_pkg::cmd_t  cmd;
  dvrt_pkg::stat_t st;
  logic            busy;

  assign in_stall = busy;

  dvrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  dvrt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .neighbor_addr   (neighbor_addr),
    .sequence_req    (sequence_req),
    .randomness      (randomness),
    .dest_addr       (dest_addr),
    .adv_distance    (adv_distance),
    .adv_metric      (adv_metric),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .neighbor_slot   (neighbor_slot),
    .neighbor_metric (neighbor_metric),
    .route_action    (route_action),
    .route_slot      (route_slot),
    .route_metric    (route_metric),
    .next_hop        (next_hop),
    .route_total     (route_total),
    .neighbor_full   (neighbor_full)
  );

`ifndef SYNTHESIS
  // an accepted word always keeps the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("engine idle right after accepting a word");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> route_total <= 6'(dvrt_pkg::RT_SLOTS))
    else $error("route count beyond table size");

  // a refused neighbor leaves the per-item fields cleared
  a_nfull_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && neighbor_full |->
      route_action == dvrt_pkg::ACT_FULL && neighbor_slot == 5'd0 && route_metric == 8'd0)
    else $error("neighbor-full result carries stale fields");
`endif

endmodule
`default_nettype wire

@@ design/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/dvrt_ctrl.sv @@
// Sequencing state machine for the route table engine.
`default_nettype none
module dvrt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire dvrt_pkg::stat_t st,
  output dvrt_pkg::cmd_t      cmd,
  output logic                busy
);

  dvrt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dvrt_pkg::ST_IDLE: begin
        if (in_valid) state_next = dvrt_pkg::ST_NRD;
      end
      dvrt_pkg::ST_NRD: begin
        // entered after load and after each neighbor miss: kind now registered
        if (st.kind == dvrt_pkg::KIND_NONE) begin
          state_next = dvrt_pkg::ST_IDLE;
        end else if (st.kind == dvrt_pkg::KIND_LOOKUP) begin
          state_next = dvrt_pkg::ST_RRD;
        end else if (st.n_end) begin
          if (st.kind == dvrt_pkg::KIND_HELLO && !st.n_full) state_next = dvrt_pkg::ST_HMUL;
          else state_next = dvrt_pkg::ST_OUT;
        end else begin
          state_next = dvrt_pkg::ST_NCMP;
        end
      end
      dvrt_pkg::ST_NCMP: begin
        if (!st.n_match) state_next = dvrt_pkg::ST_NRD;
        else if (st.kind == dvrt_pkg::KIND_HELLO) state_next = dvrt_pkg::ST_HMUL;
        else state_next = dvrt_pkg::ST_RMUL;
      end
      dvrt_pkg::ST_HMUL: state_next = dvrt_pkg::ST_HFIN;
      dvrt_pkg::ST_HFIN: state_next = dvrt_pkg::ST_OWN;
      dvrt_pkg::ST_RMUL: state_next = dvrt_pkg::ST_DIVI;
      dvrt_pkg::ST_DIVI: state_next = dvrt_pkg::ST_DIV;
      dvrt_pkg::ST_DIV: begin
        if (st.div_done) state_next = dvrt_pkg::ST_DIVF;
      end
      dvrt_pkg::ST_DIVF: state_next = dvrt_pkg::ST_OWN;
      dvrt_pkg::ST_OWN: begin
        if (st.own_match) state_next = dvrt_pkg::ST_OUT;
        else state_next = dvrt_pkg::ST_RRD;
      end
      dvrt_pkg::ST_RRD: begin
        if (st.r_end) state_next = dvrt_pkg::ST_OUT;
        else state_next = dvrt_pkg::ST_RCMP;
      end
      dvrt_pkg::ST_RCMP: begin
        if (st.r_match) state_next = dvrt_pkg::ST_OUT;
        else state_next = dvrt_pkg::ST_RRD;
      end
      dvrt_pkg::ST_OUT: begin
        if (st.out_free) state_next = dvrt_pkg::ST_IDLE;
      end
      default: state_next = dvrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.act = dvrt_pkg::ACT_ADDED;
    busy = 1'b1;
    case (state)
      dvrt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      dvrt_pkg::ST_NRD: begin
        if (st.kind == dvrt_pkg::KIND_HELLO || st.kind == dvrt_pkg::KIND_ROUTE) begin
          if (st.n_end) begin
            if (st.kind == dvrt_pkg::KIND_ROUTE) begin
              cmd.act_we = 1'b1;
              cmd.act    = dvrt_pkg::ACT_UNKNOWN;
            end else if (st.n_full) begin
              cmd.act_we    = 1'b1;
              cmd.act       = dvrt_pkg::ACT_FULL;
              cmd.set_nfull = 1'b1;
            end else begin
              cmd.nbr_new = 1'b1;
            end
          end else begin
            cmd.nbr_rd = 1'b1;
          end
        end else if (st.kind == dvrt_pkg::KIND_LOOKUP) begin
          cmd.act_we = 1'b1;
          cmd.act    = dvrt_pkg::ACT_MISSED;
        end
      end
      dvrt_pkg::ST_NCMP: begin
        cmd.nbr_latch = 1'b1;
        if (!st.n_match) cmd.idx_inc = 1'b1;
      end
      dvrt_pkg::ST_HMUL: cmd.hello_mul = 1'b1;
      dvrt_pkg::ST_HFIN: cmd.hello_fin = 1'b1;
      dvrt_pkg::ST_RMUL: cmd.route_mul = 1'b1;
      dvrt_pkg::ST_DIVI: cmd.div_start = 1'b1;
      dvrt_pkg::ST_DIV:  cmd.div_step  = 1'b1;
      dvrt_pkg::ST_DIVF: cmd.div_fin   = 1'b1;
      dvrt_pkg::ST_OWN: begin
        cmd.idx_clr = 1'b1;
        if (st.own_match) begin
          cmd.act_we = 1'b1;
          cmd.act    = dvrt_pkg::ACT_OWN;
        end
      end
      dvrt_pkg::ST_RRD: begin
        if (st.r_end) begin
          if (st.kind != dvrt_pkg::KIND_LOOKUP) begin
            cmd.act_we = 1'b1;
            if (st.r_full) begin
              cmd.act = dvrt_pkg::ACT_FULL;
            end else begin
              cmd.act    = dvrt_pkg::ACT_ADDED;
              cmd.rt_add = 1'b1;
            end
          end
        end else begin
          cmd.rt_rd = 1'b1;
        end
      end
      dvrt_pkg::ST_RCMP: begin
        if (!st.r_match) cmd.idx_inc = 1'b1;
        else if (st.kind == dvrt_pkg::KIND_LOOKUP) cmd.hit_lookup = 1'b1;
        else cmd.hit_offer = 1'b1;
      end
      dvrt_pkg::ST_OUT: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/dvrt_dp.sv @@
// Datapath: config registers, neighbor and route memories, metric arithmetic, result word.
`default_nettype none
module dvrt_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [dvrt_pkg::ADDR_W-1:0]   cfg_data,
  input  wire logic [1:0]                    kind,
  input  wire logic [dvrt_pkg::ADDR_W-1:0]   neighbor_addr,
  input  wire logic [7:0]                    sequence_req,
  input  wire logic [7:0]                    randomness,
  input  wire logic [dvrt_pkg::ADDR_W-1:0]   dest_addr,
  input  wire logic [7:0]                    adv_distance,
  input  wire logic [7:0]                    adv_metric,
  input  wire logic                          out_stall,
  input  wire dvrt_pkg::cmd_t                cmd,
  output dvrt_pkg::stat_t                    st,
  output logic                               out_valid,
  output logic [4:0]                         neighbor_slot,
  output logic [7:0]                         neighbor_metric,
  output logic [2:0]                         route_action,
  output logic [4:0]                         route_slot,
  output logic [7:0]                         route_metric,
  output logic [dvrt_pkg::ADDR_W-1:0]        next_hop,
  output logic [5:0]                         route_total,
  output logic                               neighbor_full
);

  localparam int AW = dvrt_pkg::ADDR_W;

  // config
  logic [AW-1:0] own_addr;
  logic [8:0]    succ_wt, rand_wt;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
      succ_wt  <= dvrt_pkg::SUCC_WT_RESET;
      rand_wt  <= dvrt_pkg::RAND_WT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dvrt_pkg::CFG_OWN_ADDR: own_addr <= cfg_data;
        dvrt_pkg::CFG_SUCC_WT:  succ_wt  <= cfg_data[8:0];
        dvrt_pkg::CFG_RAND_WT:  rand_wt  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // latched item
  dvrt_pkg::kind_t kind_r;
  logic [AW-1:0]   naddr, dest;
  logic [7:0]      seq, rnd, amet, hops;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_r <= dvrt_pkg::KIND_NONE;
    end else if (cmd.load) begin
      kind_r <= dvrt_pkg::kind_t'(kind);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      naddr <= neighbor_addr;
      dest  <= dest_addr;
      seq   <= sequence_req;
      rnd   <= randomness;
      amet  <= adv_metric;
      if (dvrt_pkg::kind_t'(kind) == dvrt_pkg::KIND_HELLO) hops <= 8'd1;
      else if (adv_distance == 8'hFF) hops <= 8'hFF;
      else hops <= adv_distance + 8'd1;
    end
  end

  // search index and fill counts
  logic [dvrt_pkg::IDX_W-1:0]  idx;
  logic [dvrt_pkg::NCNT_W-1:0] nbr_count;
  logic [dvrt_pkg::RCNT_W-1:0] rt_count;
  logic                        new_nbr;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      nbr_count <= '0;
      rt_count  <= '0;
      new_nbr   <= 1'b0;
    end else begin
      if (cmd.load || cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      else if (cmd.nbr_new) idx <= dvrt_pkg::IDX_W'(nbr_count);
      if (cmd.load) new_nbr <= 1'b0;
      else if (cmd.nbr_new) new_nbr <= 1'b1;
      if (cmd.hello_fin && new_nbr) nbr_count <= nbr_count + 1'b1;
      if (cmd.rt_add) rt_count <= rt_count + 1'b1;
    end
  end

  // neighbor memory: {address, last seq, success, link metric}
  logic [dvrt_pkg::NBR_W-1:0] nbr_rdata, nbr_wdata;
  logic [7:0]                 n_seq, n_succ, n_lm, succ_r, met_h;
  logic [16:0]                p_succ, p_rand;
  logic [17:0]                p_sum;

  assign p_sum = {1'b0, p_succ} + {1'b0, p_rand};
  assign met_h = (p_sum[17:16] != 2'b00) ? 8'hFF : p_sum[15:8];
  assign nbr_wdata = {naddr, seq, succ_r, met_h};

  dvrt_ram #(.WIDTH(dvrt_pkg::NBR_W), .DEPTH(dvrt_pkg::NBR_SLOTS)) u_nbr_ram (
    .clk   (clk),
    .we    (cmd.hello_fin),
    .waddr (idx[dvrt_pkg::NBR_AW-1:0]),
    .wdata (nbr_wdata),
    .re    (cmd.nbr_rd),
    .raddr (idx[dvrt_pkg::NBR_AW-1:0]),
    .rdata (nbr_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.nbr_latch) begin
      n_seq  <= nbr_rdata[23:16];
      n_succ <= nbr_rdata[15:8];
      n_lm   <= nbr_rdata[7:0];
    end
  end

  // success update from the sequence gap
  logic [7:0] gap, base, loss, succ_new;

  always_comb begin
    gap  = seq - n_seq;
    base = (new_nbr || gap == 8'd0) ? 8'hFF : n_succ;
    if (new_nbr || gap <= 8'd1) loss = 8'd0;
    else if (gap < 8'd16) loss = {gap[3:0], 4'b0000};
    else loss = 8'hFF;
    succ_new = (base > loss) ? base - loss : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.hello_mul) begin
      succ_r <= succ_new;
      p_succ <= 17'(succ_new) * 17'(succ_wt);
      p_rand <= 17'(rnd) * 17'(rand_wt);
    end
  end

  // blended metric: (lm + am*(hops-1)) / hops, one quotient bit a cycle
  logic [15:0] prod, num;
  logic [7:0]  rem;
  logic [3:0]  dcnt;
  logic [8:0]  rem_sh;

  assign rem_sh = {rem, num[15]};

  always_ff @(posedge clk) begin
    if (cmd.route_mul) begin
      prod <= 16'(amet) * 16'(hops - 8'd1);
    end
    if (cmd.div_start) begin
      num  <= 16'(n_lm) + prod;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 4'd1;
      if (rem_sh >= {1'b0, hops}) begin
        rem <= 8'(rem_sh - {1'b0, hops});
        num <= {num[14:0], 1'b1};
      end else begin
        rem <= rem_sh[7:0];
        num <= {num[14:0], 1'b0};
      end
    end
  end

  // route memory: {dest, next hop, hops, metric}
  logic [AW-1:0]             off_dest;
  logic [7:0]                om;
  logic [dvrt_pkg::RT_W-1:0] rt_rdata, rt_wdata;
  logic [AW-1:0]             rt_dest, rt_nh;
  logic [7:0]                rt_hops, rt_met;
  logic                      take;
  logic [dvrt_pkg::RT_AW-1:0] rt_waddr;

  assign off_dest = (kind_r == dvrt_pkg::KIND_ROUTE || kind_r == dvrt_pkg::KIND_LOOKUP)
                    ? dest : naddr;
  assign rt_wdata = {off_dest, naddr, hops, om};
  assign {rt_dest, rt_nh, rt_hops, rt_met} = rt_rdata;
  assign take = (rt_nh == naddr) || (hops < rt_hops) || (hops == rt_hops && om > rt_met);
  assign rt_waddr = cmd.rt_add ? rt_count[dvrt_pkg::RT_AW-1:0] : idx[dvrt_pkg::RT_AW-1:0];

  dvrt_ram #(.WIDTH(dvrt_pkg::RT_W), .DEPTH(dvrt_pkg::RT_SLOTS)) u_rt_ram (
    .clk   (clk),
    .we    (cmd.rt_add || (cmd.hit_offer && take)),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .re    (cmd.rt_rd),
    .raddr (idx[dvrt_pkg::RT_AW-1:0]),
    .rdata (rt_rdata)
  );

  // result word under construction
  logic [4:0]      r_nslot, r_rslot;
  logic [7:0]      r_nmet, r_rmet;
  dvrt_pkg::act_t  r_act;
  logic [AW-1:0]   r_nhop;
  logic            r_nfull;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_nslot <= '0;
      r_rslot <= '0;
      r_nmet  <= '0;
      r_rmet  <= '0;
      r_act   <= dvrt_pkg::ACT_ADDED;
      r_nhop  <= '0;
      r_nfull <= 1'b0;
    end else begin
      if (cmd.act_we) r_act <= cmd.act;
      if (cmd.set_nfull) r_nfull <= 1'b1;
      if (cmd.hello_fin) begin
        r_nslot <= 5'(idx);
        r_nmet  <= met_h;
        r_rmet  <= met_h;
        om      <= met_h;
      end
      if (cmd.route_mul) begin
        r_nslot <= 5'(idx);
        r_nmet  <= n_lm;
      end
      if (cmd.div_fin) begin
        r_rmet <= num[7:0];
        om     <= num[7:0];
      end
      if (cmd.rt_add) r_rslot <= 5'(rt_count);
      if (cmd.hit_lookup) begin
        r_act   <= dvrt_pkg::ACT_FOUND;
        r_rslot <= 5'(idx);
        r_rmet  <= rt_met;
        r_nhop  <= rt_nh;
      end
      if (cmd.hit_offer) begin
        r_rslot <= 5'(idx);
        r_act   <= take ? dvrt_pkg::ACT_REPLACED : dvrt_pkg::ACT_REJECTED;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      neighbor_slot   <= r_nslot;
      neighbor_metric <= r_nmet;
      route_action    <= r_act;
      route_slot      <= r_rslot;
      route_metric    <= r_rmet;
      next_hop        <= r_nhop;
      route_total     <= 6'(rt_count);
      neighbor_full   <= r_nfull;
    end
  end

  always_comb begin
    st.kind      = kind_r;
    st.n_end     = (dvrt_pkg::NCNT_W'(idx) >= nbr_count);
    st.n_match   = (nbr_rdata[dvrt_pkg::NBR_W-1 -: AW] == naddr);
    st.n_full    = (nbr_count >= dvrt_pkg::NCNT_W'(dvrt_pkg::NBR_SLOTS));
    st.own_match = (off_dest == own_addr);
    st.r_end     = (dvrt_pkg::RCNT_W'(idx) >= rt_count);
    st.r_match   = (rt_dest == off_dest);
    st.r_full    = (rt_count >= dvrt_pkg::RCNT_W'(dvrt_pkg::RT_SLOTS));
    st.div_done  = (dcnt == 4'd15);
    st.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

@@ dv/tb_distance_vector_route_table.sv @@
// Self-checking testbench for the distance-vector route table engine.
`default_nettype none
module tb_distance_vector_route_table;
  import dvrt_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [47:0] naddr;
    logic [7:0]  seq;
    logic [7:0]  rnd;
    logic [47:0] dest;
    logic [7:0]  adist;
    logic [7:0]  ametric;
  } word_t;

  typedef struct {
    logic [4:0]  nslot;
    logic [7:0]  nmetric;
    act_t        act;
    logic [4:0]  rslot;
    logic [7:0]  rmetric;
    logic [47:0] nhop;
    logic [5:0]  rtotal;
    logic        nfull;
  } route_res_t;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] kind = '0;
  logic [47:0] neighbor_addr = '0, dest_addr = '0;
  logic [7:0] sequence_req = '0, randomness = '0, adv_distance = '0, adv_metric = '0;
  logic out_valid, out_stall = 0;
  logic [4:0] neighbor_slot, route_slot;
  logic [7:0] neighbor_metric, route_metric;
  logic [2:0] route_action;
  logic [47:0] next_hop;
  logic [5:0] route_total;
  logic neighbor_full;

  distance_vector_route_table uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  logic [47:0] own_addr = '0;
  int succ_wt = SUCC_WT_RESET, rand_wt = RAND_WT_RESET;
  logic [47:0] nb_addr[NBR_SLOTS];
  logic [7:0] nb_seq[NBR_SLOTS], nb_succ[NBR_SLOTS], nb_metric[NBR_SLOTS];
  int nb_cnt = 0;
  logic [47:0] rt_dst[RT_SLOTS], rt_nh[RT_SLOTS];
  int rt_hop[RT_SLOTS], rt_met[RT_SLOTS];
  int rt_cnt = 0;

  word_t pending_words[$];
  route_res_t expected_routes[$];
  int errors = 0;
  int accepted_words = 0;
  int cycles = 0;
  bit hold_req = 0;

  function automatic int find_nbr(logic [47:0] a);
    for (int i = 0; i < nb_cnt; i++)
      if (nb_addr[i] == a) return i;
    return -1;
  endfunction

  task automatic offer(input logic [47:0] d, input logic [47:0] nh, input int hops,
                       input int met, output act_t act, output logic [4:0] slot);
    bit take;
    slot = '0;
    if (d == own_addr) begin
      act = ACT_OWN;
      return;
    end
    for (int i = 0; i < rt_cnt; i++) begin
      if (rt_dst[i] == d) begin
        slot = i[4:0];
        take = (rt_nh[i] == nh) || (hops < rt_hop[i]) ||
               (hops == rt_hop[i] && met > rt_met[i]);
        if (!take) begin
          act = ACT_REJECTED;
          return;
        end
        rt_nh[i] = nh;
        rt_hop[i] = hops;
        rt_met[i] = met;
        act = ACT_REPLACED;
        return;
      end
    end
    if (rt_cnt >= RT_SLOTS) begin
      act = ACT_FULL;
      return;
    end
    rt_dst[rt_cnt] = d;
    rt_nh[rt_cnt] = nh;
    rt_hop[rt_cnt] = hops;
    rt_met[rt_cnt] = met;
    slot = rt_cnt[4:0];
    rt_cnt++;
    act = ACT_ADDED;
  endtask

  task automatic predict_route(input word_t w, output bit has, output route_res_t r);
    int n, idx, succ, loss, gap, m, hops;
    r = '{default: '0, act: ACT_ADDED};
    has = 1;
    case (w.kind)
      KIND_NONE: has = 0;
      KIND_HELLO: begin
        n = find_nbr(w.naddr);
        if (n < 0 && nb_cnt >= NBR_SLOTS) begin
          r.nfull = 1;
          r.act = ACT_FULL;
        end else begin
          loss = 0;
          if (n < 0) begin
            idx = nb_cnt;
            nb_cnt++;
            nb_addr[idx] = w.naddr;
            succ = 255;
          end else begin
            idx = n;
            gap = (w.seq - nb_seq[idx]) & 8'hff;
            succ = nb_succ[idx];
            if (gap == 0) succ = 255;
            else if (gap == 1) loss = 0;
            else if (gap < 16) loss = 16 * gap;
            else loss = 255;
          end
          succ = (succ > loss) ? succ - loss : 0;
          m = (succ * succ_wt + w.rnd * rand_wt) >> 8;
          if (m > 255) m = 255;
          nb_seq[idx] = w.seq;
          nb_succ[idx] = succ[7:0];
          nb_metric[idx] = m[7:0];
          r.nslot = idx[4:0];
          r.nmetric = m[7:0];
          offer(w.naddr, w.naddr, 1, m, r.act, r.rslot);
          r.rmetric = m[7:0];
        end
      end
      KIND_ROUTE: begin
        n = find_nbr(w.naddr);
        if (n < 0) r.act = ACT_UNKNOWN;
        else begin
          hops = w.adist + 1;
          if (hops > 255) hops = 255;
          m = (nb_metric[n] + w.ametric * (hops - 1)) / hops;
          r.nslot = n[4:0];
          r.nmetric = nb_metric[n];
          offer(w.dest, w.naddr, hops, m, r.act, r.rslot);
          r.rmetric = m[7:0];
        end
      end
      default: begin
        r.act = ACT_MISSED;
        for (int i = 0; i < rt_cnt; i++) begin
          if (rt_dst[i] == w.dest) begin
            r.act = ACT_FOUND;
            r.rslot = i[4:0];
            r.rmetric = rt_met[i][7:0];
            r.nhop = rt_nh[i];
            break;
          end
        end
      end
    endcase
    r.rtotal = rt_cnt[5:0];
  endtask

  function automatic void check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s expected %0h actual %0h", name, e, a);
      errors++;
    end
  endfunction

  // input acceptance, prediction, and output checking
  always @(posedge clk) begin
    word_t w;
    bit has;
    route_res_t r, e;
    cycles++;
    if (!rst && in_valid && !in_stall) begin
      w.kind = kind_t'(kind);
      w.naddr = neighbor_addr;
      w.seq = sequence_req;
      w.rnd = randomness;
      w.dest = dest_addr;
      w.adist = adv_distance;
      w.ametric = adv_metric;
      predict_route(w, has, r);
      if (has) expected_routes.push_back(r);
      accepted_words++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_routes.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        e = expected_routes.pop_front();
        check_field("neighbor_slot", e.nslot, neighbor_slot);
        check_field("neighbor_metric", e.nmetric, neighbor_metric);
        check_field("route_action", e.act, route_action);
        check_field("route_slot", e.rslot, route_slot);
        check_field("route_metric", e.rmetric, route_metric);
        check_field("next_hop", e.nhop, next_hop);
        check_field("route_total", e.rtotal, route_total);
        check_field("neighbor_full", e.nfull, neighbor_full);
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("distance_vector_route_table test failed");
      $finish;
    end
  end

  // sender: bursts with random gaps
  int seen_words = 0, burst_left = 4, gap_left = 0;
  always @(negedge clk) begin
    word_t w;
    if (!rst && !(in_valid && accepted_words == seen_words)) begin
      seen_words = accepted_words;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        kind <= w.kind;
        neighbor_addr <= w.naddr;
        sequence_req <= w.seq;
        randomness <= w.rnd;
        dest_addr <= w.dest;
        adv_distance <= w.adist;
        adv_metric <= w.ametric;
        in_valid <= 1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else
        in_valid <= 0;
    end
  end

  // receiver: stall pattern drawn at random from four modes, plus one long hold-off
  int stall_mode = 0, stall_tick = 0, hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 800;
    end
    if (++stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (stall_tick % 5 < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
  end

  logic [47:0] nbr_pool[40], dest_pool[48];
  logic [7:0] sent_seq[logic [47:0]];

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_OWN_ADDR) own_addr = val;
    else if (idx == CFG_SUCC_WT) succ_wt = val[8:0];
    else rand_wt = val[8:0];
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic add_word(input kind_t k, input logic [47:0] na, input logic [7:0] sq,
                          input logic [7:0] rn, input logic [47:0] d,
                          input logic [7:0] ad, input logic [7:0] am);
    pending_words.push_back('{k, na, sq, rn, d, ad, am});
  endtask

  task automatic hello(input logic [47:0] na, input int gap, input logic [7:0] rn);
    logic [7:0] s;
    s = sent_seq.exists(na) ? sent_seq[na] + gap[7:0] : 8'($urandom);
    sent_seq[na] = s;
    add_word(KIND_HELLO, na, s, rn, rand48(), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_words(input int count);
    int sel, g;
    logic [7:0] ad;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        sel = $urandom_range(0, 9);
        g = (sel < 3) ? 1 : (sel < 4) ? 0 : (sel < 7) ? $urandom_range(2, 15) :
            (sel < 8) ? 16 : $urandom_range(0, 255);
        hello(nbr_pool[$urandom_range(0, 39)], g, 8'($urandom));
      end else if (sel < 70) begin
        ad = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
        add_word(KIND_ROUTE,
                 ($urandom_range(0, 9) == 0) ? rand48() : nbr_pool[$urandom_range(0, 39)],
                 8'($urandom), 8'($urandom), dest_pool[$urandom_range(0, 47)], ad,
                 8'($urandom));
      end else if (sel < 97) begin
        add_word(KIND_LOOKUP, rand48(), 8'($urandom), 8'($urandom),
                 ($urandom_range(0, 7) == 0) ? rand48() : dest_pool[$urandom_range(0, 47)],
                 8'($urandom), 8'($urandom));
      end else
        add_word(KIND_NONE, rand48(), 8'($urandom), 8'($urandom), rand48(),
                 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid);
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sw[5], rw[5];
    nbr_pool[0] = '0;
    nbr_pool[1] = '1;
    for (int i = 2; i < 40; i++) nbr_pool[i] = rand48();
    for (int i = 0; i < 48; i++) dest_pool[i] = (i < 16) ? nbr_pool[i * 2] : rand48();
    sw = '{205, 0, 256, 256, 0};
    rw = '{51, 0, 256, 0, 0};
    sw[4] = $urandom_range(0, 256);
    rw[4] = $urandom_range(0, 256);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: a lookup on the empty table, own address, gap cases, saturation
    add_word(KIND_LOOKUP, '0, '0, '0, '0, '0, '0);
    add_word(KIND_ROUTE, nbr_pool[2], '0, '0, nbr_pool[3], 8'd3, 8'd9);
    hello(nbr_pool[0], 1, 8'd0);
    hello(nbr_pool[1], 1, 8'hff);
    hello(nbr_pool[1], 1, 8'hff);
    hello(nbr_pool[1], 2, 8'h80);
    hello(nbr_pool[1], 15, 8'h7f);
    hello(nbr_pool[1], 0, 8'h01);
    hello(nbr_pool[1], 16, 8'h10);
    hello(nbr_pool[1], 200, 8'hff);
    hello(nbr_pool[2], 1, 8'h55);
    add_word(KIND_ROUTE, nbr_pool[2], '0, '0, dest_pool[20], 8'd0, 8'hff);
    add_word(KIND_ROUTE, nbr_pool[2], '0, '0, dest_pool[21], 8'd255, 8'hff);
    add_word(KIND_ROUTE, nbr_pool[1], '0, '0, dest_pool[21], 8'd255, 8'd0);
    add_word(KIND_ROUTE, nbr_pool[1], '0, '0, dest_pool[20], 8'd2, 8'd0);
    add_word(KIND_ROUTE, nbr_pool[1], '0, '0, dest_pool[20], 8'd0, 8'hff);
    add_word(KIND_ROUTE, nbr_pool[2], '0, '0, '0, 8'd1, 8'd1);
    add_word(KIND_ROUTE, nbr_pool[2], '0, '0, '1, 8'd1, 8'd1);
    add_word(KIND_LOOKUP, '0, '0, '0, dest_pool[21], '0, '0);
    add_word(KIND_LOOKUP, '0, '0, '0, '1, '0, '0);
    add_word(KIND_NONE, '1, '1, '1, '1, '1, '1);
    for (int i = 3; i < 36; i++) hello(nbr_pool[i], 1, 8'($urandom));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(CFG_OWN_ADDR, (ph == 2) ? '1 : nbr_pool[$urandom_range(0, 39)]);
      write_reg(CFG_SUCC_WT, 48'(sw[ph]));
      write_reg(CFG_RAND_WT, 48'(rw[ph]));
      if (ph == 2) hold_req = 1;
      random_words(ph == 0 ? 180 : 230);
    end
    drain();
    if (errors == 0)
      $display("distance_vector_route_table test passed");
    else
      $display("distance_vector_route_table test failed");
    $finish;
  end

endmodule
`default_nettype wire
